// ===== hw/rtl/fba_pkg.sv =====
// fba_pkg: shared types, widths and codes of the fit block allocator.
// No dependencies; the interfaces and the top level import it.
`timescale 1ns / 1ps

package fba_pkg;

   localparam int OpW   = 3;
   localparam int SizeW = 24;
   localparam int IdW   = 16;
   localparam int CntW  = 7;
   localparam int StW   = 2;
   localparam int HdrW  = 8;
   localparam int CsrIdxW = 2;

   // opcodes
   localparam logic [OpW-1:0] OP_ALLOC  = 3'd0;
   localparam logic [OpW-1:0] OP_FREE   = 3'd1;
   localparam logic [OpW-1:0] OP_DEFRAG = 3'd2;
   localparam logic [OpW-1:0] OP_CLEAR  = 3'd3;

   // result status
   localparam logic [StW-1:0] ST_OK        = 2'd0;
   localparam logic [StW-1:0] ST_POOL_FULL = 2'd1;
   localparam logic [StW-1:0] ST_TBL_FULL  = 2'd2;
   localparam logic [StW-1:0] ST_NO_ID     = 2'd3;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_FIT_STRATEGY = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_POOL_BYTES   = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_HEADER_BYTES = 2'd2;

   localparam logic [SizeW-1:0] SIZE_MAX = 24'hFFFFFF;

   // one entry of the entry memory (link pointer lives in its own memory)
   typedef struct packed {
      logic [IdW-1:0]   ident;
      logic [SizeW-1:0] length;
      logic             is_free;
      logic [SizeW-1:0] location;
   } entry_type;

endpackage

// ===== hw/rtl/fba_req_if.sv =====
// fba_req_if: request channel (valid/ready plus request item payload).
// Depends on fba_pkg.
`timescale 1ns / 1ps

interface fba_req_if import fba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OpW-1:0]   opcode;
   logic [SizeW-1:0] alloc_size;
   logic [IdW-1:0]   target_id;

   modport source (output valid, opcode, alloc_size, target_id, input ready);
   modport sink   (input valid, opcode, alloc_size, target_id, output ready);
endinterface

// ===== hw/rtl/fba_rsp_if.sv =====
// fba_rsp_if: response channel (valid/ready plus result item payload).
// Depends on fba_pkg.
`timescale 1ns / 1ps

interface fba_rsp_if import fba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [StW-1:0]   status;
   logic [SizeW-1:0] block_address;
   logic [IdW-1:0]   assigned_id;
   logic [CntW-1:0]  used_blocks;
   logic [CntW-1:0]  free_blocks;
   logic [CntW-1:0]  total_blocks;
   logic [SizeW-1:0] total_size;
   logic [SizeW-1:0] free_size;

   modport source (output valid, status, block_address, assigned_id, used_blocks,
                   free_blocks, total_blocks, total_size, free_size, input ready);
   modport sink   (input valid, status, block_address, assigned_id, used_blocks,
                   free_blocks, total_blocks, total_size, free_size, output ready);
endinterface

// ===== hw/rtl/fit_block_allocator.sv =====
// fit_block_allocator: first/best fit block allocator over a linked entry list.
// Depends on fba_pkg, fba_req_if and fba_rsp_if.
//
//   channel   dir   handshake          payload
//   req       in    valid/ready        opcode, alloc_size, target_id
//   rsp       out   valid/ready        status, address, id, counts, byte sums
//   csr       in    csr_we             csr_index, csr_wdata
//
// One item at a time. Each list walk visits one entry per cycle from the entry
// memories (one read port each). Alloc: walk for a reusable free entry, else a
// scan for an unused slot and an append at the break; free: walk for the
// target id; defrag: a merging walk; then a recount walk over the whole list.
// Reset is synchronous; the entry memories are not cleared (only reached via
// the list). A pending result waits in the output register; the finished
// result of the next item holds until the previous one is taken.
`timescale 1ns / 1ps

module fit_block_allocator import fba_pkg::*; #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic                clock,
   input  logic                reset,
   fba_req_if.sink             req,
   fba_rsp_if.source           rsp,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [SizeW-1:0]    csr_wdata
);

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int LW = $clog2(MAX_BLOCKS + 1);
   localparam logic [LW-1:0] LINK_NULL = LW'(MAX_BLOCKS);
   localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_BLOCKS - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FIND   = 4'd1;
   localparam logic [3:0] S_REUSE  = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_LINK   = 4'd4;
   localparam logic [3:0] S_FREE   = 4'd5;
   localparam logic [3:0] S_DEFCUR = 4'd6;
   localparam logic [3:0] S_DEFNX  = 4'd7;
   localparam logic [3:0] S_CNTGO  = 4'd8;
   localparam logic [3:0] S_CNT    = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   // entry memories
   entry_type       mem_a [MAX_BLOCKS];
   logic [LW-1:0]   mem_b [MAX_BLOCKS];
   entry_type       a_rd_ff;
   logic [LW-1:0]   b_rd_ff;

   logic [LW-1:0]   rd_slot;
   logic [AW-1:0]   rd_addr;
   logic            wa_en, wb_en;
   logic [AW-1:0]   wa_addr, wb_addr;
   entry_type       wa_data;
   logic [LW-1:0]   wb_data;

   // control and list state
   logic [3:0]            state_ff, state_in;
   logic [AW-1:0]         t_ff, t_in, nx_ff, nx_in, scan_ff, scan_in;
   logic                  pick_vld_ff, pick_vld_in;
   logic [AW-1:0]         pick_ff, pick_in;
   entry_type             pick_ent_ff, pick_ent_in;
   entry_type             cur_ff, cur_in;
   logic [LW-1:0]         cur_link_ff, cur_link_in;
   logic                  dirty_ff, dirty_in;
   logic [SizeW-1:0]      size_ff, size_in;
   logic [IdW-1:0]        tid_ff, tid_in;
   logic [MAX_BLOCKS-1:0] map_ff, map_in;
   logic [LW-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [IdW-1:0]        next_id_ff, next_id_in;
   logic [SizeW:0]        brk_ff, brk_in;

   // working result
   logic [StW-1:0]   st_ff, st_in;
   logic [SizeW-1:0] addr_ff, addr_in;
   logic [IdW-1:0]   aid_ff, aid_in;
   logic [CntW-1:0]  c_used_ff, c_used_in, c_free_ff, c_free_in, c_tot_ff, c_tot_in;
   logic [SizeW-1:0] s_tot_ff, s_tot_in, s_free_ff, s_free_in;

   // configuration
   logic             strat_ff;
   logic [SizeW-1:0] pool_ff;
   logic [HdrW-1:0]  hdr_ff;

   // output register
   logic             rsp_vld_ff, rsp_vld_in, load_out;
   logic [StW-1:0]   o_st_ff;
   logic [SizeW-1:0] o_addr_ff, o_stot_ff, o_sfree_ff;
   logic [IdW-1:0]   o_aid_ff;
   logic [CntW-1:0]  o_used_ff, o_free_ff, o_tot_ff;

   logic             accept, take, link_null, merge;
   logic [SizeW+1:0] end_sum;
   logic [SizeW:0]   sum_a, sum_b, sum_m;
   logic [SizeW-1:0] new_loc;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign link_null = (b_rd_ff == LINK_NULL);
   assign rd_addr   = rd_slot[AW-1:0];

   assign take = a_rd_ff.is_free && (a_rd_ff.length >= size_ff) &&
                 (!strat_ff || !pick_vld_ff || (a_rd_ff.length < pick_ent_ff.length));
   assign end_sum = {1'b0, brk_ff} + (SizeW+2)'(hdr_ff) + (SizeW+2)'(size_ff);
   assign new_loc = brk_ff[SizeW-1:0] + SizeW'(hdr_ff);
   assign merge   = cur_ff.is_free && a_rd_ff.is_free;
   assign sum_m   = {1'b0, cur_ff.length} + {1'b0, a_rd_ff.length};
   assign sum_a   = {1'b0, s_tot_ff} + {1'b0, a_rd_ff.length};
   assign sum_b   = {1'b0, s_free_ff} + {1'b0, a_rd_ff.length};

   // memories: registered read, one write port each
   always_ff @(posedge clock) begin
      a_rd_ff <= mem_a[rd_addr];
      b_rd_ff <= mem_b[rd_addr];
      if (wa_en) begin
         mem_a[wa_addr] <= wa_data;
      end
      if (wb_en) begin
         mem_b[wb_addr] <= wb_data;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      t_in        = t_ff;
      nx_in       = nx_ff;
      scan_in     = scan_ff;
      pick_vld_in = pick_vld_ff;
      pick_in     = pick_ff;
      pick_ent_in = pick_ent_ff;
      cur_in      = cur_ff;
      cur_link_in = cur_link_ff;
      dirty_in    = dirty_ff;
      size_in     = size_ff;
      tid_in      = tid_ff;
      map_in      = map_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      next_id_in  = next_id_ff;
      brk_in      = brk_ff;
      st_in       = st_ff;
      addr_in     = addr_ff;
      aid_in      = aid_ff;
      c_used_in   = c_used_ff;
      c_free_in   = c_free_ff;
      c_tot_in    = c_tot_ff;
      s_tot_in    = s_tot_ff;
      s_free_in   = s_free_ff;
      rd_slot     = head_ff;
      wa_en       = 1'b0;
      wa_addr     = t_ff;
      wa_data     = cur_ff;
      wb_en       = 1'b0;
      wb_addr     = t_ff;
      wb_data     = cur_link_ff;
      load_out    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               size_in     = req.alloc_size;
               tid_in      = req.target_id;
               st_in       = ST_OK;
               addr_in     = '0;
               aid_in      = '0;
               pick_vld_in = 1'b0;
               scan_in     = '0;
               t_in        = head_ff[AW-1:0];
               unique case (req.opcode)
                  OP_ALLOC: begin
                     state_in = (head_ff == LINK_NULL) ? S_SCAN : S_FIND;
                  end
                  OP_FREE: begin
                     if (head_ff == LINK_NULL) begin
                        st_in    = ST_NO_ID;
                        state_in = S_CNTGO;
                     end else begin
                        state_in = S_FREE;
                     end
                  end
                  OP_DEFRAG: begin
                     state_in = (head_ff == LINK_NULL) ? S_CNTGO : S_DEFCUR;
                  end
                  OP_CLEAR: begin
                     map_in     = '0;
                     head_in    = LINK_NULL;
                     tail_in    = LINK_NULL;
                     next_id_in = IdW'(1);
                     state_in   = S_CNTGO;
                  end
                  default: begin
                     state_in = S_CNTGO;
                  end
               endcase
            end
         end

         // walk for a reusable free entry
         S_FIND: begin
            if (take) begin
               pick_vld_in = 1'b1;
               pick_in     = t_ff;
               pick_ent_in = a_rd_ff;
            end
            if (take && !strat_ff) begin
               state_in = S_REUSE;
            end else if (link_null) begin
               state_in = (pick_vld_ff || take) ? S_REUSE : S_SCAN;
            end else begin
               rd_slot = b_rd_ff;
               t_in    = b_rd_ff[AW-1:0];
            end
         end

         S_REUSE: begin
            wa_en           = 1'b1;
            wa_addr         = pick_ff;
            wa_data         = pick_ent_ff;
            wa_data.length  = size_ff;
            wa_data.is_free = 1'b0;
            addr_in         = pick_ent_ff.location;
            aid_in          = pick_ent_ff.ident;
            state_in        = S_CNTGO;
         end

         // look for an unused slot, then append at the break
         S_SCAN: begin
            if (!map_ff[scan_ff]) begin
               if (end_sum > (SizeW+2)'(pool_ff)) begin
                  st_in    = ST_POOL_FULL;
                  state_in = S_CNTGO;
               end else begin
                  wa_en            = 1'b1;
                  wa_addr          = scan_ff;
                  wa_data.ident    = next_id_ff;
                  wa_data.length   = size_ff;
                  wa_data.is_free  = 1'b0;
                  wa_data.location = new_loc;
                  wb_en            = 1'b1;
                  wb_addr          = scan_ff;
                  wb_data          = LINK_NULL;
                  map_in[scan_ff]  = 1'b1;
                  brk_in           = end_sum[SizeW:0];
                  addr_in          = new_loc;
                  aid_in           = next_id_ff;
                  next_id_in       = (next_id_ff == '1) ? IdW'(1) : next_id_ff + IdW'(1);
                  tail_in          = LW'(scan_ff);
                  if (tail_ff == LINK_NULL) begin
                     head_in  = LW'(scan_ff);
                     state_in = S_CNTGO;
                  end else begin
                     t_in     = tail_ff[AW-1:0];
                     nx_in    = scan_ff;
                     state_in = S_LINK;
                  end
               end
            end else if (scan_ff == LAST_SLOT) begin
               st_in    = ST_TBL_FULL;
               state_in = S_CNTGO;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end

         S_LINK: begin
            wb_en    = 1'b1;
            wb_addr  = t_ff;
            wb_data  = LW'(nx_ff);
            state_in = S_CNTGO;
         end

         // walk for the first entry with the target id
         S_FREE: begin
            if (a_rd_ff.ident == tid_ff) begin
               wa_en           = 1'b1;
               wa_addr         = t_ff;
               wa_data         = a_rd_ff;
               wa_data.is_free = 1'b1;
               state_in        = S_CNTGO;
            end else if (link_null) begin
               st_in    = ST_NO_ID;
               state_in = S_CNTGO;
            end else begin
               rd_slot = b_rd_ff;
               t_in    = b_rd_ff[AW-1:0];
            end
         end

         // defrag: hold the current entry, compare against its successor
         S_DEFCUR: begin
            cur_in      = a_rd_ff;
            cur_link_in = b_rd_ff;
            dirty_in    = 1'b0;
            if (link_null) begin
               state_in = S_CNTGO;
            end else begin
               rd_slot  = b_rd_ff;
               nx_in    = b_rd_ff[AW-1:0];
               state_in = S_DEFNX;
            end
         end

         S_DEFNX: begin
            if (merge) begin
               cur_in.length = sum_m[SizeW] ? SIZE_MAX : sum_m[SizeW-1:0];
               cur_link_in   = b_rd_ff;
               map_in[nx_ff] = 1'b0;
               if (tail_ff == LW'(nx_ff)) begin
                  tail_in = LW'(t_ff);
               end
               if (link_null) begin
                  wa_en        = 1'b1;
                  wa_data      = cur_in;
                  wb_en        = 1'b1;
                  wb_data      = b_rd_ff;
                  state_in     = S_CNTGO;
               end else begin
                  dirty_in = 1'b1;
                  rd_slot  = b_rd_ff;
                  nx_in    = b_rd_ff[AW-1:0];
               end
            end else begin
               wa_en       = dirty_ff;
               wb_en       = dirty_ff;
               t_in        = nx_ff;
               cur_in      = a_rd_ff;
               cur_link_in = b_rd_ff;
               dirty_in    = 1'b0;
               if (link_null) begin
                  state_in = S_CNTGO;
               end else begin
                  rd_slot = b_rd_ff;
                  nx_in   = b_rd_ff[AW-1:0];
               end
            end
         end

         // recount over the whole list
         S_CNTGO: begin
            c_used_in = '0;
            c_free_in = '0;
            c_tot_in  = '0;
            s_tot_in  = '0;
            s_free_in = '0;
            state_in  = (head_ff == LINK_NULL) ? S_DONE : S_CNT;
         end

         S_CNT: begin
            c_tot_in = c_tot_ff + CntW'(1);
            s_tot_in = sum_a[SizeW] ? SIZE_MAX : sum_a[SizeW-1:0];
            if (a_rd_ff.is_free) begin
               c_free_in = c_free_ff + CntW'(1);
               s_free_in = sum_b[SizeW] ? SIZE_MAX : sum_b[SizeW-1:0];
            end else begin
               c_used_in = c_used_ff + CntW'(1);
            end
            if (link_null) begin
               state_in = S_DONE;
            end else begin
               rd_slot = b_rd_ff;
            end
         end

         S_DONE: begin
            if (!rsp_vld_ff || rsp.ready) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_vld_in = load_out ? 1'b1 : (rsp.ready ? 1'b0 : rsp_vld_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         map_ff      <= '0;
         head_ff     <= LINK_NULL;
         tail_ff     <= LINK_NULL;
         next_id_ff  <= IdW'(1);
         brk_ff      <= '0;
         pick_vld_ff <= 1'b0;
         dirty_ff    <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         strat_ff    <= 1'b0;
         pool_ff     <= SIZE_MAX;
         hdr_ff      <= HdrW'(40);
      end else begin
         state_ff    <= state_in;
         map_ff      <= map_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         next_id_ff  <= next_id_in;
         brk_ff      <= brk_in;
         pick_vld_ff <= pick_vld_in;
         dirty_ff    <= dirty_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FIT_STRATEGY: strat_ff <= csr_wdata[0];
               CSR_POOL_BYTES:   pool_ff  <= csr_wdata;
               CSR_HEADER_BYTES: hdr_ff   <= csr_wdata[HdrW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      nx_ff       <= nx_in;
      scan_ff     <= scan_in;
      pick_ff     <= pick_in;
      pick_ent_ff <= pick_ent_in;
      cur_ff      <= cur_in;
      cur_link_ff <= cur_link_in;
      size_ff     <= size_in;
      tid_ff      <= tid_in;
      st_ff       <= st_in;
      addr_ff     <= addr_in;
      aid_ff      <= aid_in;
      c_used_ff   <= c_used_in;
      c_free_ff   <= c_free_in;
      c_tot_ff    <= c_tot_in;
      s_tot_ff    <= s_tot_in;
      s_free_ff   <= s_free_in;
      if (load_out) begin
         o_st_ff    <= st_ff;
         o_addr_ff  <= (st_ff == ST_OK) ? addr_ff : '0;
         o_aid_ff   <= (st_ff == ST_OK) ? aid_ff : '0;
         o_used_ff  <= c_used_ff;
         o_free_ff  <= c_free_ff;
         o_tot_ff   <= c_tot_ff;
         o_stot_ff  <= s_tot_ff;
         o_sfree_ff <= s_free_ff;
      end
   end

   assign rsp.valid         = rsp_vld_ff;
   assign rsp.status        = o_st_ff;
   assign rsp.block_address = o_addr_ff;
   assign rsp.assigned_id   = o_aid_ff;
   assign rsp.used_blocks   = o_used_ff;
   assign rsp.free_blocks   = o_free_ff;
   assign rsp.total_blocks  = o_tot_ff;
   assign rsp.total_size    = o_stot_ff;
   assign rsp.free_size     = o_sfree_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for fit_block_allocator; a built-in allocator
// model predicts each result. Depends on fba_pkg, fba_req_if, fba_rsp_if and the RTL.
`timescale 1ns / 1ps

module tb_top;
   import fba_pkg::*;

   localparam int                NumSlots  = 64;
   localparam int                LinkNull  = NumSlots;
   localparam logic [OpW-1:0]    OP_STATUS = 3'd4;
   localparam logic [OpW-1:0]    OP_SPARE5 = 3'd5;
   localparam logic [OpW-1:0]    OP_SPARE6 = 3'd6;
   localparam logic [OpW-1:0]    OP_SPARE7 = 3'd7;
   localparam int                DrainWait = 300;

   typedef struct packed {
      logic [OpW-1:0]   opcode;
      logic [SizeW-1:0] alloc_size;
      logic [IdW-1:0]   target_id;
   } alloc_req_type;

   typedef struct packed {
      logic [StW-1:0]   status;
      logic [SizeW-1:0] block_address;
      logic [IdW-1:0]   assigned_id;
      logic [CntW-1:0]  used_blocks;
      logic [CntW-1:0]  free_blocks;
      logic [CntW-1:0]  total_blocks;
      logic [SizeW-1:0] total_size;
      logic [SizeW-1:0] free_size;
   } alloc_rsp_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [SizeW-1:0] csr_wdata;

   fba_req_if req ();
   fba_rsp_if rsp ();

   fit_block_allocator uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   alloc_req_type pending_reqs[$];
   alloc_rsp_type expected_rsps[$];
   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int rsp_count;
   int status_hist[4];

   // ---- allocator model state ----
   logic [IdW-1:0]   m_ident[NumSlots];
   logic [SizeW-1:0] m_length[NumSlots];
   logic             m_is_free[NumSlots];
   logic [SizeW-1:0] m_location[NumSlots];
   int               m_link[NumSlots];
   logic             m_slot_used[NumSlots];
   int               m_head;
   int               m_tail;
   logic [IdW-1:0]   m_next_id;
   logic [24:0]      m_break;
   logic             m_best_fit;
   logic [SizeW-1:0] m_pool;
   logic [HdrW-1:0]  m_header;

   function automatic logic [SizeW-1:0] sat_sum(logic [SizeW-1:0] a, logic [SizeW-1:0] b);
      logic [SizeW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SizeW] ? SIZE_MAX : s[SizeW-1:0];
   endfunction

   function automatic void clear_model_list();
      foreach (m_slot_used[i]) m_slot_used[i] = 1'b0;
      m_head = LinkNull;
      m_tail = LinkNull;
      m_next_id = IdW'(1);
   endfunction

   // alloc: reuse a free entry (first or smallest fit), else append at the break
   function automatic logic [StW-1:0] model_alloc(logic [SizeW-1:0] size,
                                                  output logic [SizeW-1:0] addr,
                                                  output logic [IdW-1:0] id);
      int t;
      int pick;
      int slot;
      logic [25:0] end_addr;
      addr = '0;
      id = '0;
      pick = LinkNull;
      t = m_head;
      while (t < NumSlots) begin
         if (m_is_free[t] && m_length[t] >= size) begin
            if (!m_best_fit) begin
               pick = t;
               break;
            end
            if (pick == LinkNull || m_length[t] < m_length[pick]) pick = t;
         end
         t = m_link[t];
      end
      if (pick != LinkNull) begin
         m_is_free[pick] = 1'b0;
         m_length[pick] = size;
         addr = m_location[pick];
         id = m_ident[pick];
         return ST_OK;
      end
      slot = LinkNull;
      for (int i = 0; i < NumSlots; i++) begin
         if (!m_slot_used[i]) begin
            slot = i;
            break;
         end
      end
      if (slot == LinkNull) return ST_TBL_FULL;
      end_addr = {1'b0, m_break} + 26'(m_header) + 26'(size);
      if (end_addr > 26'(m_pool)) return ST_POOL_FULL;
      m_slot_used[slot] = 1'b1;
      m_ident[slot] = m_next_id;
      m_length[slot] = size;
      m_is_free[slot] = 1'b0;
      m_location[slot] = m_break[SizeW-1:0] + SizeW'(m_header);
      m_link[slot] = LinkNull;
      if (m_tail != LinkNull) m_link[m_tail] = slot;
      else m_head = slot;
      m_tail = slot;
      m_break = end_addr[24:0];
      addr = m_location[slot];
      id = m_next_id;
      m_next_id = (m_next_id == 16'hFFFF) ? 16'd1 : m_next_id + 16'd1;
      return ST_OK;
   endfunction

   function automatic logic [StW-1:0] model_free(logic [IdW-1:0] id);
      int t;
      t = m_head;
      while (t < NumSlots) begin
         if (m_ident[t] == id) begin
            m_is_free[t] = 1'b1;
            return ST_OK;
         end
         t = m_link[t];
      end
      return ST_NO_ID;
   endfunction

   // merge each run of adjacent free entries into its first entry
   function automatic void model_defrag();
      int t;
      int nx;
      t = m_head;
      while (t < NumSlots) begin
         nx = m_link[t];
         if (nx >= NumSlots) break;
         if (m_is_free[t] && m_is_free[nx]) begin
            m_length[t] = sat_sum(m_length[t], m_length[nx]);
            m_link[t] = m_link[nx];
            m_slot_used[nx] = 1'b0;
            if (m_tail == nx) m_tail = t;
         end else begin
            t = nx;
         end
      end
   endfunction

   function automatic alloc_rsp_type predict_alloc_rsp(alloc_req_type it);
      alloc_rsp_type r;
      logic [SizeW-1:0] addr;
      logic [IdW-1:0] id;
      int t;
      r = '0;
      addr = '0;
      id = '0;
      case (it.opcode)
         OP_ALLOC:  r.status = model_alloc(it.alloc_size, addr, id);
         OP_FREE:   r.status = model_free(it.target_id);
         OP_DEFRAG: model_defrag();
         OP_CLEAR:  clear_model_list();
         default:   ;
      endcase
      if (r.status == ST_OK) begin
         r.block_address = addr;
         r.assigned_id = id;
      end
      t = m_head;
      while (t < NumSlots) begin
         r.total_blocks++;
         r.total_size = sat_sum(r.total_size, m_length[t]);
         if (m_is_free[t]) begin
            r.free_blocks++;
            r.free_size = sat_sum(r.free_size, m_length[t]);
         end else begin
            r.used_blocks++;
         end
         t = m_link[t];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // ---- clock, reset, run limit ----
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #60ms;
      $display("fit_block_allocator: mismatch");
      $finish;
   end

   // ---- request driver: predict on acceptance, then offer the next item ----
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready)
            expected_rsps.push_back(predict_alloc_rsp({req.opcode, req.alloc_size,
                                                       req.target_id}));
         if (!req.valid || req.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               alloc_req_type it;
               it = pending_reqs.pop_front();
               req.valid <= 1'b1;
               req.opcode <= it.opcode;
               req.alloc_size <= it.alloc_size;
               req.target_id <= it.target_id;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // ---- result monitor ----
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            rsp_count++;
            status_hist[rsp.status]++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("result with none pending", rsp.status, -1);
            end else begin
               alloc_rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp.status !== e.status) report_mismatch("status", rsp.status, e.status);
               if (rsp.block_address !== e.block_address)
                  report_mismatch("block_address", rsp.block_address, e.block_address);
               if (rsp.assigned_id !== e.assigned_id)
                  report_mismatch("assigned_id", rsp.assigned_id, e.assigned_id);
               if (rsp.used_blocks !== e.used_blocks)
                  report_mismatch("used_blocks", rsp.used_blocks, e.used_blocks);
               if (rsp.free_blocks !== e.free_blocks)
                  report_mismatch("free_blocks", rsp.free_blocks, e.free_blocks);
               if (rsp.total_blocks !== e.total_blocks)
                  report_mismatch("total_blocks", rsp.total_blocks, e.total_blocks);
               if (rsp.total_size !== e.total_size)
                  report_mismatch("total_size", rsp.total_size, e.total_size);
               if (rsp.free_size !== e.free_size)
                  report_mismatch("free_size", rsp.free_size, e.free_size);
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---- stimulus helpers ----
   function automatic void push_item(logic [OpW-1:0] op, logic [SizeW-1:0] size,
                                     logic [IdW-1:0] id);
      alloc_req_type it;
      it.opcode = op;
      it.alloc_size = size;
      it.target_id = id;
      pending_reqs.push_back(it);
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req.valid || expected_rsps.size() != 0);
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] idx, logic [SizeW-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FIT_STRATEGY: m_best_fit = value[0];
         CSR_POOL_BYTES:   m_pool = value;
         CSR_HEADER_BYTES: m_header = value[HdrW-1:0];
         default:          ;
      endcase
   endtask

   // small sizes keep the break low; now and then a large one
   function automatic logic [SizeW-1:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 85) return SizeW'($urandom_range(4095));
      if (r < 97) return SizeW'($urandom_range(65535));
      return SizeW'($urandom);
   endfunction

   // one stretch of random traffic, mostly alloc/free workloads over live ids
   function automatic void push_random(int count);
      int gen_ids;
      int n;
      int k;
      gen_ids = 0;
      n = 0;
      while (n < count) begin
         k = $urandom_range(99);
         if (k < 60) begin
            repeat ($urandom_range(8, 2)) begin
               if ($urandom_range(99) < 55) begin
                  push_item(OP_ALLOC, pick_size(), IdW'($urandom));
                  gen_ids++;
               end else begin
                  push_item(OP_FREE, SizeW'($urandom),
                            IdW'($urandom_range(gen_ids + 2, 1)));
               end
               n++;
            end
            if ($urandom_range(3) == 0) begin
               push_item(OP_DEFRAG, SizeW'($urandom), IdW'($urandom));
               n++;
            end
         end else if (k < 66) begin
            // fill the table past its limit, then punch holes and merge
            push_item(OP_CLEAR, SizeW'($urandom), IdW'($urandom));
            gen_ids = 0;
            repeat (66) begin
               push_item(OP_ALLOC, SizeW'($urandom_range(64)), IdW'($urandom));
               gen_ids++;
            end
            repeat (12) push_item(OP_FREE, SizeW'($urandom), IdW'($urandom_range(64, 1)));
            push_item(OP_DEFRAG, SizeW'($urandom), IdW'($urandom));
            repeat (4) push_item(OP_ALLOC, SizeW'($urandom_range(200)), IdW'($urandom));
            n += 84;
         end else if (k < 72) begin
            push_item(OP_CLEAR, SizeW'($urandom), IdW'($urandom));
            gen_ids = 0;
            n++;
         end else begin
            // noise: any opcode, any field bits
            push_item(OpW'($urandom), SizeW'($urandom), IdW'($urandom));
            n++;
         end
      end
   endfunction

   // ---- run sequence ----
   initial begin
      int idle_modes[4][2];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.opcode = '0;
      req.alloc_size = '0;
      req.target_id = '0;
      rsp.ready = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      error_count = 0;
      rsp_count = 0;
      foreach (status_hist[i]) status_hist[i] = 0;
      foreach (m_ident[i]) begin
         m_ident[i] = '0;
         m_length[i] = '0;
         m_is_free[i] = 1'b0;
         m_location[i] = '0;
         m_link[i] = 0;
      end
      clear_model_list();
      m_break = '0;
      m_best_fit = 1'b0;
      m_pool = SIZE_MAX;
      m_header = 8'd40;
      idle_modes = '{'{0, 0}, '{45, 0}, '{0, 45}, '{16, 16}};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, zero size, oversize, reuse, double free, odd ids
      push_item(OP_STATUS, '0, '0);
      push_item(OP_ALLOC, '0, '0);
      push_item(OP_ALLOC, SIZE_MAX, '0);
      push_item(OP_ALLOC, 24'd100, '0);
      push_item(OP_ALLOC, 24'd200, '0);
      push_item(OP_ALLOC, 24'd50, '0);
      push_item(OP_FREE, '0, 16'd2);
      push_item(OP_FREE, '0, 16'd2);
      push_item(OP_FREE, '0, 16'd0);
      push_item(OP_FREE, '0, 16'hFFFF);
      push_item(OP_FREE, '0, 16'd3);
      push_item(OP_ALLOC, '0, '0);
      push_item(OP_FREE, '0, 16'd1);
      push_item(OP_FREE, '0, 16'd4);
      push_item(OP_DEFRAG, SIZE_MAX, 16'hFFFF);
      push_item(OP_ALLOC, 24'd120, '0);
      push_item(OP_SPARE5, SIZE_MAX, 16'hFFFF);
      push_item(OP_SPARE6, '0, '0);
      push_item(OP_SPARE7, '0, '0);
      push_item(OP_CLEAR, '0, '0);
      push_item(OP_STATUS, '0, '0);
      wait_drained();
      repeat (DrainWait) @(posedge clock);

      // configuration phases: strategy, pool, header; idling rotates per phase
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_csr(CSR_FIT_STRATEGY, 24'd1);
               write_csr(CSR_HEADER_BYTES, 24'd0);
            end
            1: begin
               write_csr(CSR_HEADER_BYTES, 24'd255);
               write_csr(CSR_POOL_BYTES, SIZE_MAX);
            end
            2: begin
               // pool held just above the break: most appends run dry
               write_csr(CSR_FIT_STRATEGY, 24'd0);
               write_csr(CSR_POOL_BYTES, SizeW'(m_break) + 24'd3000);
            end
            3: write_csr(CSR_POOL_BYTES, 24'd0);
            4: begin
               write_csr(CSR_POOL_BYTES, SIZE_MAX);
               write_csr(CSR_HEADER_BYTES, 24'd8);
               write_csr(CSR_FIT_STRATEGY, 24'd1);
            end
            default: write_csr(CSR_FIT_STRATEGY, 24'd0);
         endcase
         send_idle_pct = idle_modes[ph % 4][0];
         recv_idle_pct = idle_modes[ph % 4][1];
         push_random(100);
         // sender holds off until every result is back
         wait_drained();
         push_random(100);
         wait_drained();
         repeat (DrainWait) @(posedge clock);
      end

      $display("covered %0d results: ok %0d, pool dry %0d, table full %0d, unknown id %0d",
               rsp_count, status_hist[ST_OK], status_hist[ST_POOL_FULL],
               status_hist[ST_TBL_FULL], status_hist[ST_NO_ID]);
      $display("first and best fit, pool and header extremes, four idling mixes");
      if (error_count == 0) begin
         $display("fit_block_allocator: match");
      end else begin
         $display("fit_block_allocator: mismatch");
      end
      $finish;
   end

endmodule
